// ----- rtl/core/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared item types, kind codes and controller states of the signature scan
// prefilter core.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam logic [2:0] KIND_SCAN  = 3'd0;
  localparam logic [2:0] KIND_TOP   = 3'd1;
  localparam logic [2:0] KIND_BYTE  = 3'd2;
  localparam logic [2:0] KIND_REC   = 3'd3;
  localparam logic [2:0] KIND_BUILD = 3'd4;

  localparam int CFG_W = 13;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  slot;
    logic [11:0] sig_index;
    logic [3:0]  byte_pos;
    logic [4:0]  sig_length;
    logic [15:0] virus_id;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] match_id;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  len;
    logic [15:0] id;
  } sig_rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_BIT,
    ST_CHK,
    ST_RD,
    ST_CMP,
    ST_FIN,
    ST_BMAP,
    ST_BCLR,
    ST_BRD,
    ST_BEV
  } state_t;

endpackage

// ----- rtl/core/ssp_sig_mem.sv -----
// ----------------------------------------------------------------------------
// ssp_sig_mem
// Signature store: one row of bytes per signature, written a byte at a time,
// and a record memory with compare length and id. One registered read port.
// ----------------------------------------------------------------------------
module ssp_sig_mem #(
  parameter int DEPTH     = 4096,
  parameter int AW        = 12,
  parameter int SIG_BYTES = 16,
  parameter int BPW       = 4
) (
  input  logic                        clk,
  input  logic                        byte_we,
  input  logic                        rec_we,
  input  logic [AW-1:0]               wr_addr,
  input  logic [BPW-1:0]              wr_pos,
  input  logic [7:0]                  wr_byte,
  input  ssp_pkg::sig_rec_t           wr_rec,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [SIG_BYTES-1:0][7:0]   rd_row,
  output ssp_pkg::sig_rec_t           rd_rec
);

  logic [SIG_BYTES-1:0][7:0] row_mem [DEPTH];
  ssp_pkg::sig_rec_t         rec_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (byte_we) begin
      row_mem[wr_addr][wr_pos] <= wr_byte;
    end
    if (rec_we) begin
      rec_mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_row <= row_mem[rd_addr];
      rd_rec <= rec_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/ssp_bit_mem.sv -----
// ----------------------------------------------------------------------------
// ssp_bit_mem
// Per-slot bit tables, one bit per entry, addressed by {slot, key}.
// ----------------------------------------------------------------------------
module ssp_bit_mem #(
  parameter int BAW = 16
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [BAW-1:0] wr_addr,
  input  logic           wr_bit,
  input  logic           rd_en,
  input  logic [BAW-1:0] rd_addr,
  output logic           rd_bit
);

  logic bit_mem [2**BAW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bit_mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_bit <= bit_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/ssp_map.sv -----
// ----------------------------------------------------------------------------
// ssp_map
// Byte-to-slot map: slot numbers in a memory, one valid flag per byte value
// in flops so that a build can drop the whole map with a single clear.
// ----------------------------------------------------------------------------
module ssp_map #(
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr_all,
  input  logic          wr_en,
  input  logic [7:0]    wr_byte,
  input  logic [SW-1:0] wr_slot,
  input  logic          rd_en,
  input  logic [7:0]    rd_byte,
  output logic          rd_valid,
  output logic [SW-1:0] rd_slot
);

  logic [255:0]  valid_r;
  logic [SW-1:0] slot_mem [256];

  assign rd_valid = valid_r[rd_byte];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr_all) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_byte] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_byte] <= wr_slot;
    end
    if (rd_en) begin
      rd_slot <= slot_mem[rd_byte];
    end
  end

endmodule

// ----- rtl/core/signature_scan_prefilter_bsearch_core.sv -----
// ----------------------------------------------------------------------------
// signature_scan_prefilter_bsearch_core
// Multi-pattern signature scanner with a per-slot bit-table prefilter and a
// binary search over the slot's run of sorted signatures.
// ----------------------------------------------------------------------------
// Usage: load items (kinds 1 to 3) fill the top bytes and signature store,
// a build item (kind 4) rebuilds the byte map, runs and bit tables, then
// scan items (kind 0) stream buffer bytes, last_byte marking the end.
// cfg_wr_en/cfg_wr_data set the signature count used by the next build.
// Input and result channels use valid/stall; one item is in work at a time
// and in_stall stays high until it finishes. A result sits in an output
// register, so the next item is taken while the receiver stalls it; a new
// result waits in the finish step until that register is free.
// Steps per item: load items finish in idle; a scan byte that examines no
// start goes to the finish step, one rejected by the map after the map read,
// one rejected by the bit table or an empty run after the bit read and check,
// and one that is searched after its probes (probe = one read of the signature
// memory, then compare), at most floor(log2(run)) + 1 of them. A build writes
// the map for each slot, then per slot clears 2**(16 - TABLE_SHIFT) bit-table
// entries and reads signatures up to the end of that slot's run or the count.
// Synchronous reset empties the map, runs and window; the bit tables need no
// clearing pass as no start reaches them before a build, which clears them.
// ----------------------------------------------------------------------------
module signature_scan_prefilter_bsearch_core #(
  parameter int MAX_SIGS     = 4096,
  parameter int SIG_BYTES    = 16,
  parameter int TOP_SETS     = 16,
  parameter int TABLE_SHIFT  = 4,
  parameter int ENCRYPT_FROM = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ssp_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ssp_pkg::out_item_t        out_item,
  input  logic                      cfg_wr_en,
  input  logic [ssp_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int AW      = (MAX_SIGS > 1) ? $clog2(MAX_SIGS) : 1;
  localparam int CW      = $clog2(MAX_SIGS + 1);
  localparam int SW      = (TOP_SETS > 1) ? $clog2(TOP_SETS) : 1;
  localparam int TKW     = 16 - TABLE_SHIFT;
  localparam int BAW     = SW + TKW;
  localparam int WIN_LEN = SIG_BYTES + 1;
  localparam int FW      = $clog2(WIN_LEN + 1);
  localparam int BPW     = $clog2(SIG_BYTES);

  ssp_pkg::state_t state_r, state_nxt;

  logic [ssp_pkg::CFG_W-1:0] sig_count_r;
  logic [7:0]                top_bytes_r [TOP_SETS];
  logic [TOP_SETS-1:0]       run_valid_r;
  logic [AW-1:0]             run_low_r  [TOP_SETS];
  logic [AW-1:0]             run_high_r [TOP_SETS];
  logic [7:0]                win_r [WIN_LEN];
  logic [FW-1:0]             fill_r, fill_nxt;
  logic                      mr_r;
  logic                      last_r;
  logic                      hit_r;
  logic [15:0]               hit_id_r;
  logic [SW-1:0]             slot_r;
  logic [CW-1:0]             lo_r, hip1_r;
  logic [SW-1:0]             bs_r;
  logic [TKW-1:0]            clr_r;
  logic [CW-1:0]             j_r, n_r;
  logic                      in_run_r;
  logic                      out_valid_r;
  ssp_pkg::out_item_t        out_item_r;

  logic                      acc;
  logic                      examine;
  logic [AW-1:0]             mid;
  logic [CW:0]               mid_sum;
  logic                      cmp_diff, cmp_less;
  logic                      need_emit, can_emit, emit_now;
  logic                      slot_last;
  logic                      bev_match;
  logic [TKW-1:0]            win_key, row_key;
  logic [CW-1:0]             n_sat;

  // memory controls
  logic                       sig_byte_we, sig_rec_we, sig_rd_en;
  logic [AW-1:0]              sig_wr_addr, sig_rd_addr;
  logic [BPW-1:0]             sig_wr_pos;
  ssp_pkg::sig_rec_t          sig_wr_rec, sig_rd_rec;
  logic [SIG_BYTES-1:0][7:0]  sig_rd_row;
  logic                       bit_we, bit_wbit, bit_re, bit_q;
  logic [BAW-1:0]             bit_waddr, bit_raddr;
  logic                       map_clr, map_we, map_re, map_valid;
  logic [7:0]                 map_wbyte;
  logic [SW-1:0]              map_q;

  ssp_sig_mem #(
    .DEPTH(MAX_SIGS), .AW(AW), .SIG_BYTES(SIG_BYTES), .BPW(BPW)
  ) u_sig_mem (
    .clk(clk), .byte_we(sig_byte_we), .rec_we(sig_rec_we), .wr_addr(sig_wr_addr),
    .wr_pos(sig_wr_pos), .wr_byte(in_item.data_byte), .wr_rec(sig_wr_rec),
    .rd_en(sig_rd_en), .rd_addr(sig_rd_addr), .rd_row(sig_rd_row), .rd_rec(sig_rd_rec)
  );

  ssp_bit_mem #(.BAW(BAW)) u_bit_mem (
    .clk(clk), .wr_en(bit_we), .wr_addr(bit_waddr), .wr_bit(bit_wbit),
    .rd_en(bit_re), .rd_addr(bit_raddr), .rd_bit(bit_q)
  );

  ssp_map #(.SW(SW)) u_map (
    .clk(clk), .rst_n(rst_n), .clr_all(map_clr), .wr_en(map_we), .wr_byte(map_wbyte),
    .wr_slot(bs_r), .rd_en(map_re), .rd_byte(win_r[0]), .rd_valid(map_valid),
    .rd_slot(map_q)
  );

  assign in_stall  = (state_r != ssp_pkg::ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign fill_nxt  = (32'(fill_r) < WIN_LEN) ? fill_r + FW'(1) : fill_r;
  // the window is shifted at this edge: examine once it is full, unless a match was reported
  assign examine   = (32'(fill_nxt) == WIN_LEN) && !mr_r;

  assign win_key   = TKW'({win_r[1], win_r[2]} >> TABLE_SHIFT);
  assign row_key   = TKW'({sig_rd_row[1], sig_rd_row[2]} >> TABLE_SHIFT);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hip1_r} - (CW+1)'(1);
  assign mid       = AW'(mid_sum >> 1);
  assign n_sat     = (32'(sig_count_r) > MAX_SIGS) ? CW'(MAX_SIGS) : CW'(sig_count_r);
  assign slot_last = (32'(bs_r) == TOP_SETS - 1);
  assign bev_match = (sig_rd_row[0] == top_bytes_r[bs_r]);

  assign need_emit = hit_r || (last_r && !mr_r);
  assign can_emit  = !out_valid_r || !out_stall;
  assign emit_now  = (state_r == ssp_pkg::ST_FIN) && need_emit && can_emit;

  // first differing byte within the signature length decides the order
  always_comb begin
    logic [7:0] db;
    cmp_diff = 1'b0;
    cmp_less = 1'b0;
    db       = '0;
    for (int i = 0; i < SIG_BYTES; i++) begin
      db = win_r[i] + ((i >= ENCRYPT_FROM) ? 8'd1 : 8'd0);
      if (!cmp_diff && (i < int'(sig_rd_rec.len)) && (db != sig_rd_row[i])) begin
        cmp_diff = 1'b1;
        cmp_less = (db < sig_rd_row[i]);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssp_pkg::ST_IDLE: begin
        if (acc && in_item.kind == ssp_pkg::KIND_SCAN) begin
          state_nxt = examine ? ssp_pkg::ST_MAP : ssp_pkg::ST_FIN;
        end else if (acc && in_item.kind == ssp_pkg::KIND_BUILD) begin
          state_nxt = ssp_pkg::ST_BMAP;
        end
      end
      ssp_pkg::ST_MAP: state_nxt = map_valid ? ssp_pkg::ST_BIT : ssp_pkg::ST_FIN;
      ssp_pkg::ST_BIT: state_nxt = ssp_pkg::ST_CHK;
      ssp_pkg::ST_CHK: begin
        state_nxt = (bit_q && run_valid_r[slot_r]) ? ssp_pkg::ST_RD : ssp_pkg::ST_FIN;
      end
      ssp_pkg::ST_RD:  state_nxt = (lo_r < hip1_r) ? ssp_pkg::ST_CMP : ssp_pkg::ST_FIN;
      ssp_pkg::ST_CMP: state_nxt = cmp_diff ? ssp_pkg::ST_RD : ssp_pkg::ST_FIN;
      ssp_pkg::ST_FIN: begin
        if (!need_emit || can_emit) begin
          state_nxt = ssp_pkg::ST_IDLE;
        end
      end
      ssp_pkg::ST_BMAP: state_nxt = slot_last ? ssp_pkg::ST_BCLR : ssp_pkg::ST_BMAP;
      ssp_pkg::ST_BCLR: state_nxt = (&clr_r) ? ssp_pkg::ST_BRD : ssp_pkg::ST_BCLR;
      ssp_pkg::ST_BRD: begin
        if (j_r < n_r) begin
          state_nxt = ssp_pkg::ST_BEV;
        end else begin
          state_nxt = slot_last ? ssp_pkg::ST_IDLE : ssp_pkg::ST_BCLR;
        end
      end
      ssp_pkg::ST_BEV: begin
        if (!bev_match && in_run_r) begin
          state_nxt = slot_last ? ssp_pkg::ST_IDLE : ssp_pkg::ST_BCLR;
        end else begin
          state_nxt = ssp_pkg::ST_BRD;
        end
      end
      default: state_nxt = ssp_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    sig_byte_we = acc && (in_item.kind == ssp_pkg::KIND_BYTE)
                  && (32'(in_item.sig_index) < MAX_SIGS)
                  && (32'(in_item.byte_pos) < SIG_BYTES);
    sig_rec_we  = acc && (in_item.kind == ssp_pkg::KIND_REC)
                  && (32'(in_item.sig_index) < MAX_SIGS);
    sig_wr_addr = AW'(in_item.sig_index);
    sig_wr_pos  = BPW'(in_item.byte_pos);
    sig_wr_rec.len = (32'(in_item.sig_length) > SIG_BYTES) ? 5'(SIG_BYTES)
                                                            : in_item.sig_length;
    sig_wr_rec.id  = in_item.virus_id;
    sig_rd_en   = 1'b0;
    sig_rd_addr = mid;
    bit_we      = 1'b0;
    bit_wbit    = 1'b0;
    bit_waddr   = {bs_r, clr_r};
    bit_re      = 1'b0;
    bit_raddr   = {map_q, win_key};
    map_clr     = acc && (in_item.kind == ssp_pkg::KIND_BUILD);
    map_we      = 1'b0;
    map_wbyte   = top_bytes_r[bs_r];
    map_re      = 1'b0;
    unique case (state_r)
      ssp_pkg::ST_MAP:  map_re = 1'b1;
      ssp_pkg::ST_BIT:  bit_re = 1'b1;
      ssp_pkg::ST_RD:   sig_rd_en = (lo_r < hip1_r);
      ssp_pkg::ST_BMAP: map_we = 1'b1;
      ssp_pkg::ST_BCLR: bit_we = 1'b1;
      ssp_pkg::ST_BRD: begin
        sig_rd_en   = (j_r < n_r);
        sig_rd_addr = AW'(j_r);
      end
      ssp_pkg::ST_BEV: begin
        bit_we    = bev_match;
        bit_wbit  = 1'b1;
        bit_waddr = {bs_r, row_key};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration and load registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_count_r <= '0;
      for (int s = 0; s < TOP_SETS; s++) begin
        top_bytes_r[s] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        sig_count_r <= cfg_wr_data;
      end
      if (acc && in_item.kind == ssp_pkg::KIND_TOP && 32'(in_item.slot) < TOP_SETS) begin
        top_bytes_r[SW'(in_item.slot)] <= in_item.data_byte;
      end
    end
  end

  // scan window and search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        win_r[k] <= '0;
      end
      fill_r      <= '0;
      mr_r        <= 1'b0;
      last_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ssp_pkg::ST_IDLE: begin
          if (acc && in_item.kind == ssp_pkg::KIND_SCAN) begin
            for (int k = 0; k < WIN_LEN - 1; k++) begin
              win_r[k] <= win_r[k+1];
            end
            win_r[WIN_LEN-1] <= in_item.data_byte;
            fill_r <= fill_nxt;
            last_r <= in_item.last_byte;
            hit_r  <= 1'b0;
          end
        end
        ssp_pkg::ST_BIT: slot_r <= map_q;
        ssp_pkg::ST_CHK: begin
          lo_r   <= CW'(run_low_r[slot_r]);
          hip1_r <= CW'(run_high_r[slot_r]) + CW'(1);
        end
        ssp_pkg::ST_CMP: begin
          if (!cmp_diff) begin
            hit_r    <= 1'b1;
            hit_id_r <= sig_rd_rec.id;
          end else if (cmp_less) begin
            hip1_r <= CW'(mid);
          end else begin
            lo_r <= CW'(mid) + CW'(1);
          end
        end
        ssp_pkg::ST_FIN: begin
          if (!need_emit || can_emit) begin
            if (need_emit) begin
              out_item_r.found    <= hit_r;
              out_item_r.match_id <= hit_r ? hit_id_r : 16'd0;
            end
            hit_r <= 1'b0;
            // a buffer end always empties the window
            if (last_r) begin
              fill_r <= '0;
              mr_r   <= 1'b0;
            end else if (hit_r) begin
              mr_r <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // table build
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= '0;
      bs_r        <= '0;
      clr_r       <= '0;
      in_run_r    <= 1'b0;
    end else begin
      unique case (state_r)
        ssp_pkg::ST_IDLE: begin
          if (acc && in_item.kind == ssp_pkg::KIND_BUILD) begin
            bs_r  <= '0;
            clr_r <= '0;
            n_r   <= n_sat;
          end
        end
        ssp_pkg::ST_BMAP: begin
          bs_r <= slot_last ? '0 : bs_r + SW'(1);
        end
        ssp_pkg::ST_BCLR: begin
          clr_r <= clr_r + TKW'(1);
          if (&clr_r) begin
            run_valid_r[bs_r] <= 1'b0;
            run_low_r[bs_r]   <= '0;
            run_high_r[bs_r]  <= '0;
            in_run_r          <= 1'b0;
            j_r               <= '0;
          end
        end
        ssp_pkg::ST_BRD: begin
          if (!(j_r < n_r) && !slot_last) begin
            bs_r <= bs_r + SW'(1);
          end
        end
        ssp_pkg::ST_BEV: begin
          if (bev_match) begin
            if (!in_run_r) begin
              in_run_r          <= 1'b1;
              run_valid_r[bs_r] <= 1'b1;
              run_low_r[bs_r]   <= AW'(j_r);
            end
            run_high_r[bs_r] <= AW'(j_r);
            j_r <= j_r + CW'(1);
          end else if (in_run_r) begin
            // run ended: advance to the next slot
            if (!slot_last) begin
              bs_r <= bs_r + SW'(1);
            end
          end else begin
            j_r <= j_r + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ssp_pkg::ST_FIN))
    else $error("result raised outside the finish step");

  a_reported_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    mr_r |-> (32'(fill_r) == WIN_LEN))
    else $error("match reported on a window that is not full");

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssp_pkg::ST_CMP) |-> (lo_r < hip1_r))
    else $error("probe outside the search range");

  a_notfound_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.found) |-> (out_item_r.match_id == 16'd0))
    else $error("not-found result carries an id");

endmodule
